@@ rtl/gprc_pkg.sv @@
// Package for the modulo-two remainder check: widths, word types, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package gprc_pkg;

  // Width of codeword, generator and remainder
  localparam int WORD_BITS = 63;
  // Enough bits for a bit position or a shift count within one word
  localparam int DEG_W     = $clog2(WORD_BITS);
  // Top bits inspected per normalising step
  localparam int NORM_LOOK = 4;
  localparam int SH_W      = $clog2(NORM_LOOK + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DEG_W-1:0]     pos_t;
  typedef logic [SH_W-1:0]      shamt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_DIV,
    ST_PUT
  } gprc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new word
    logic norm;  // shift divisor towards the top bit
    logic div;   // one shift-and-xor step
    logic put;   // capture the result
  } gprc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gen_zero;   // divisor register is zero
    logic norm_done;  // divisor top bit is set
    logic last_step;  // final division step
  } gprc_stat_t;

endpackage

@@ rtl/gprc_in_if.sv @@
// Input channel: valid/ready handshake carrying codeword and generator.
// Depends on gprc_pkg.
interface gprc_in_if;
  import gprc_pkg::*;

  logic  valid;
  logic  ready;
  word_t codeword;
  word_t generator;

  modport source (output valid, output codeword, output generator, input ready);
  modport sink   (input valid, input codeword, input generator, output ready);
endinterface

@@ rtl/gprc_out_if.sv @@
// Result channel: valid/ready handshake carrying remainder and flags.
// Depends on gprc_pkg.
interface gprc_out_if;
  import gprc_pkg::*;

  logic  valid;
  logic  ready;
  word_t remainder;
  logic  good;
  logic  bad_generator;

  modport source (output valid, output remainder, output good, output bad_generator,
                  input ready);
  modport sink   (input valid, input remainder, input good, input bad_generator,
                  output ready);
endinterface

@@ rtl/gprc_ctrl.sv @@
// Controller state machine for the remainder check: sequences load,
// normalise, divide and result hand-off. Depends on gprc_pkg.
module gprc_ctrl import gprc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  gprc_stat_t stat,
  output gprc_cmd_t  cmd
);

  gprc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // result register may be refilled when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.gen_zero)       state_nxt = ST_PUT;
        else if (stat.norm_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.last_step) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_NORM: begin
        cmd.norm = !stat.gen_zero && !stat.norm_done;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_PUT: begin
        cmd.put = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.put)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/gprc_dp.sv @@
// Datapath for the remainder check: partial remainder, aligned divisor,
// bit cursor and the result register. Depends on gprc_pkg.
module gprc_dp import gprc_pkg::*; (
  input  logic       clk,
  input  gprc_cmd_t  cmd,
  output gprc_stat_t stat,
  input  word_t      in_codeword,
  input  word_t      in_generator,
  output word_t      out_remainder,
  output logic       out_good,
  output logic       out_bad_generator
);

  word_t  rem_r, rem_nxt;   // partial remainder
  word_t  div_r, div_nxt;   // divisor, aligned to the cursor
  pos_t   pos_r, pos_nxt;   // bit under test
  pos_t   left_r, left_nxt; // steps after this one
  word_t  res_r;
  logic   good_r, bad_r;
  shamt_t sh;
  logic   zero_div;

  assign zero_div       = (div_r == '0);
  assign stat.gen_zero  = zero_div;
  assign stat.norm_done = div_r[WORD_BITS-1];
  assign stat.last_step = (left_r == '0);

  // leading zeros among the top bits of the divisor, capped at the look-ahead
  always_comb begin
    sh = SH_W'(NORM_LOOK);
    for (int i = NORM_LOOK - 1; i >= 0; i--) begin
      if (div_r[WORD_BITS-1-i]) sh = SH_W'(i);
    end
  end

  // working registers
  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    pos_nxt  = pos_r;
    left_nxt = left_r;
    if (cmd.load) begin
      rem_nxt  = in_codeword;
      div_nxt  = in_generator;
      pos_nxt  = DEG_W'(WORD_BITS - 1);
      left_nxt = '0;
    end else if (cmd.norm) begin
      // left_r counts the alignment shift, i.e. steps still to run
      div_nxt  = div_r << sh;
      left_nxt = left_r + DEG_W'(sh);
    end else if (cmd.div) begin
      if (rem_r[pos_r]) rem_nxt = rem_r ^ div_r;
      if (left_r != '0) begin
        div_nxt  = div_r >> 1;
        pos_nxt  = pos_r - DEG_W'(1);
        left_nxt = left_r - DEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
  end

  // result register; a zero divisor here only arises from a zero generator
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      res_r  <= zero_div ? '0 : rem_r;
      good_r <= !zero_div && (rem_r == '0);
      bad_r  <= zero_div;
    end
  end

  assign out_remainder     = res_r;
  assign out_good          = good_r;
  assign out_bad_generator = bad_r;

endmodule

@@ rtl/gf2_polynomial_remainder_check.sv @@
// Modulo-two remainder check: divides a codeword by a generator over GF(2)
// and reports the remainder, a good flag for a zero remainder and an error
// flag for a zero generator. One word is in flight at a time. With the
// generator of degree d, the divisor is first shifted up to the top bit,
// four top bits inspected per cycle, then WORD_BITS-d shift-and-xor steps
// run, one per codeword bit from the top down, before the result is
// handed off. The next word is taken as soon as the result sits in the
// output register.
// Depends on gprc_pkg, gprc_in_if, gprc_out_if, gprc_ctrl and gprc_dp.
module gf2_polynomial_remainder_check import gprc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gprc_in_if.sink     in_ch,
  gprc_out_if.source  out_ch
);

  gprc_cmd_t  cmd;
  gprc_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  // sequencing
  gprc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // division datapath
  gprc_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .stat              (stat),
    .in_codeword       (in_ch.codeword),
    .in_generator      (in_ch.generator),
    .out_remainder     (out_ch.remainder),
    .out_good          (out_ch.good),
    .out_bad_generator (out_ch.bad_generator)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
